// ----- hw/rtl/tmplan_pkg.sv -----
package tmplan_pkg;

   localparam int MAX_STEPS_DEF = 15000;

   localparam int POS_W    = 24;
   localparam int MAXSPD_W = 12;
   localparam int ACC_W    = 12;
   localparam int SD_W     = 24;
   localparam int K_W      = 37;
   localparam int V2_W     = 24;
   localparam int DIV_W    = 40;
   localparam int FRAC_W   = 16;
   localparam int TOT_W    = 14;
   localparam int SPEED_W  = 20;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DIST   = 2'd2;

   localparam logic [MAXSPD_W-1:0] SPEED_LIMIT_RST = 12'd40;
   localparam logic [ACC_W-1:0]    ACCEL_RST       = 12'd30;
   localparam logic [SD_W-1:0]     STEP_DIST_RST   = 24'd65536;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MOVE   = 2'd2;

   localparam logic [SPEED_W-1:0] FIRST_STEP_MIN = 20'd26;
   localparam logic [SPEED_W-1:0] SPEED_SAT      = 20'hFFFFF;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } tmplan_op_type;

   typedef struct packed {
      logic          start;
      tmplan_op_type op;
   } tmplan_ctl_type;

   typedef struct packed {
      logic [MAXSPD_W-1:0] speed_limit;
      logic [SD_W-1:0]     step_dist;
      logic                sd_zero;
      logic [K_W-1:0]      k;
      logic [V2_W-1:0]     v2;
   } tmplan_cfg_type;

   // multiplier operand width of the shared unit
   function automatic int mul_bw(input int sw);
      return (sw > MAXSPD_W) ? sw : MAXSPD_W;
   endfunction

   // working register width of the shared unit, always even
   function automatic int unit_xw(input int sw);
      int mw;
      int rw;
      mw = K_W + mul_bw(sw);
      rw = mw + (mw & 1);
      return (rw > DIV_W) ? rw : DIV_W;
   endfunction

endpackage

// ----- hw/rtl/tmplan_req_if.sv -----
interface tmplan_req_if;
   import tmplan_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic signed [POS_W-1:0] target_position;

   modport source (output valid, req_type, target_position, input ready);
   modport sink   (input valid, req_type, target_position, output ready);
endinterface

// ----- hw/rtl/tmplan_rsp_if.sv -----
interface tmplan_rsp_if;
   import tmplan_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                direction;
   logic [TOT_W-1:0]    step_count;
   logic [SPEED_W-1:0]  step_speed;
   logic                last_step;

   modport source (output valid, status, direction, step_count, step_speed, last_step,
                   input ready);
   modport sink   (input valid, status, direction, step_count, step_speed, last_step,
                   output ready);
endinterface

// ----- hw/rtl/tmplan_csr_if.sv -----
interface tmplan_csr_if;
   import tmplan_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tmplan_cfg.sv -----
module tmplan_cfg (
   input  logic                   clock,
   input  logic                   reset,
   tmplan_csr_if.sink             csr_if,
   output tmplan_pkg::tmplan_cfg_type cfg
);
   import tmplan_pkg::*;

   logic [MAXSPD_W-1:0] speed_limit_ff;
   logic [ACC_W-1:0]    accel_ff;
   logic [SD_W-1:0]     step_dist_ff;
   logic [K_W-1:0]      k_ff, k_in;
   logic [V2_W-1:0]     v2_ff, v2_in;
   logic                wr;

   assign csr_if.ready = 1'b1;
   assign wr = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= SPEED_LIMIT_RST;
         accel_ff       <= ACCEL_RST;
         step_dist_ff   <= STEP_DIST_RST;
      end else if (wr) begin
         case (csr_if.index)
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_if.data[MAXSPD_W-1:0];
            CSR_ACCEL:       accel_ff       <= csr_if.data[ACC_W-1:0];
            CSR_STEP_DIST:   step_dist_ff   <= csr_if.data[SD_W-1:0];
            default: ;
         endcase
      end
   end

   // derived products, registered from the stored CSR values
   always_comb begin
      k_in  = {(K_W-1)'(accel_ff) * (K_W-1)'(step_dist_ff), 1'b0};
      v2_in = V2_W'(speed_limit_ff) * V2_W'(speed_limit_ff);
   end

   always_ff @(posedge clock) begin
      k_ff  <= k_in;
      v2_ff <= v2_in;
   end

   assign cfg.speed_limit = speed_limit_ff;
   assign cfg.step_dist   = step_dist_ff;
   assign cfg.sd_zero     = (step_dist_ff == '0);
   assign cfg.k           = k_ff;
   assign cfg.v2          = v2_ff;
endmodule

// ----- hw/rtl/tmplan_unit.sv -----
module tmplan_unit #(
   parameter int SW = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tmplan_pkg::tmplan_ctl_type             ctl,
   input  logic [tmplan_pkg::unit_xw(SW)-1:0]     opx,
   input  logic [tmplan_pkg::K_W-1:0]             opy,
   output logic                                   done,
   output logic [tmplan_pkg::unit_xw(SW)-1:0]     acc,
   output logic [tmplan_pkg::unit_xw(SW)-1:0]     quo
);
   import tmplan_pkg::*;

   localparam int BW = mul_bw(SW);
   localparam int XW = unit_xw(SW);
   localparam int RH = XW / 2;
   localparam int CW = $clog2(XW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   tmplan_op_type op_ff, op_in;
   logic [XW-1:0] x_ff, x_in;
   logic [K_W-1:0] y_ff, y_in;
   logic [XW-1:0] acc_ff, acc_in;
   logic [XW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [XW-1:0] opa, opb;
   logic          sub;
   logic [XW:0]   sum;
   logic          ge;
   logic [CW-1:0] cnt_last;

   // one add/subtract shared by multiply, divide and square root steps
   always_comb begin
      case (op_ff)
         OP_DIV: begin
            opa = XW'({acc_ff[K_W-1:0], x_ff[XW-1]});
            opb = XW'(y_ff);
            sub = 1'b1;
            cnt_last = CW'(DIV_W - 1);
         end
         OP_SQRT: begin
            opa = XW'({acc_ff[RH:0], x_ff[XW-1:XW-2]});
            opb = XW'({q_ff[RH-1:0], 2'b01});
            sub = 1'b1;
            cnt_last = CW'(RH - 1);
         end
         default: begin
            opa = {acc_ff[XW-2:0], 1'b0};
            opb = x_ff[XW-1] ? XW'(y_ff) : '0;
            sub = 1'b0;
            cnt_last = CW'(BW - 1);
         end
      endcase
      sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (XW+1)'(sub);
      ge  = sum[XW];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         y_in    = opy;
         acc_in  = '0;
         q_in    = '0;
         cnt_in  = '0;
         case (ctl.op)
            OP_DIV:  x_in = {opx[DIV_W-1:0], {(XW-DIV_W){1'b0}}};
            OP_SQRT: x_in = opx;
            default: x_in = {opx[BW-1:0], {(XW-BW){1'b0}}};
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CW'(1);
         case (op_ff)
            OP_DIV: begin
               acc_in = ge ? sum[XW-1:0] : opa;
               q_in   = {q_ff[XW-2:0], ge};
               x_in   = {x_ff[XW-2:0], 1'b0};
            end
            OP_SQRT: begin
               acc_in = ge ? sum[XW-1:0] : opa;
               q_in   = {q_ff[XW-2:0], ge};
               x_in   = {x_ff[XW-3:0], 2'b00};
            end
            default: begin
               acc_in = sum[XW-1:0];
               x_in   = {x_ff[XW-2:0], 1'b0};
            end
         endcase
         if (cnt_ff == cnt_last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quo  = q_ff;
endmodule

// ----- hw/rtl/trapezoidal_move_planner_top.sv -----
// speed request: ramp steps run S_STEP, S_SMUL, S_SSQRT, S_SFIN (a multiply and a root),
//   cruise steps S_STEP, S_SFIN, and with no move active S_STEP goes straight to S_RESP
// plan request: a rejected count or zero acceleration stops after the step-count divide;
//   full ramp adds a multiply and a divide; lowered peak: 2 divides, 3 multiplies, 1 root
// one item at a time: the next item is taken after the result beat leaves
// synchronous active-high reset: registers 40/30/65536, position zero, no move active
module trapezoidal_move_planner_top #(
   parameter int MAX_STEPS = tmplan_pkg::MAX_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tmplan_req_if.sink   req_if,
   tmplan_rsp_if.source rsp_if,
   tmplan_csr_if.sink   csr_if
);
   import tmplan_pkg::*;

   localparam int SW = $clog2(MAX_STEPS + 1);
   localparam int XW = unit_xw(SW);
   localparam int RH = XW / 2;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_DIFF  = 13'b0000000000010,
      S_NDIV  = 13'b0000000000100,
      S_NKMUL = 13'b0000000001000,
      S_PMUL  = 13'b0000000010000,
      S_PSQRT = 13'b0000000100000,
      S_PPMUL = 13'b0000001000000,
      S_RDIV  = 13'b0000010000000,
      S_STEP  = 13'b0000100000000,
      S_SMUL  = 13'b0001000000000,
      S_SSQRT = 13'b0010000000000,
      S_SFIN  = 13'b0100000000000,
      S_RESP  = 13'b1000000000000
   } state_type;

   tmplan_cfg_type cfg;
   tmplan_ctl_type ctl;
   logic [XW-1:0]  opx;
   logic [K_W-1:0] opy;
   logic           u_done;
   logic [XW-1:0]  u_acc, u_quo;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   target_ff, target_in;
   logic               neg_ff, neg_in;
   logic [SW-1:0]      n_ff, n_in;
   logic               pdir_ff, pdir_in;
   logic [POS_W-1:0]   last_pos_ff, last_pos_in;
   logic [SW-1:0]      steps_ff, steps_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      ramp_ff, ramp_in;
   logic [MAXSPD_W-1:0] peak_ff, peak_in;
   logic               dir_ff, dir_in;
   logic               active_ff, active_in;
   logic [RH-1:0]      sp_ff, sp_in;
   logic [STATUS_W-1:0] r_status_ff, r_status_in;
   logic               r_dir_ff, r_dir_in;
   logic [TOT_W-1:0]   r_total_ff, r_total_in;
   logic [SPEED_W-1:0] r_speed_ff, r_speed_in;
   logic               r_last_ff, r_last_in;

   logic [POS_W:0]     diff;
   logic [POS_W:0]     mag;
   logic [DIV_W-1:0]   nq;
   logic               n_zero;
   logic               n_bad;
   logic [SW-1:0]      n_mid;
   logic [SW-1:0]      m_sel;
   logic [SW:0]        i_inc;
   logic [RH-1:0]      sp_adj;
   logic               commit;

   tmplan_cfg u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   tmplan_unit #(.SW(SW)) u_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .opx   (opx),
      .opy   (opy),
      .done  (u_done),
      .acc   (u_acc),
      .quo   (u_quo)
   );

   always_comb begin
      diff   = {target_ff[POS_W-1], target_ff} - {last_pos_ff[POS_W-1], last_pos_ff};
      mag    = diff[POS_W] ? (~diff + (POS_W+1)'(1)) : diff;
      nq     = u_quo[DIV_W-1:0];
      n_zero = cfg.sd_zero || (nq == '0);
      n_bad  = n_zero || (nq > DIV_W'(MAX_STEPS));
      n_mid  = steps_ff - ramp_ff;
      m_sel  = (idx_ff < ramp_ff) ? idx_ff : (steps_ff - idx_ff);
      i_inc  = {1'b0, idx_ff} + (SW+1)'(1);
      sp_adj = sp_ff;
      if ((idx_ff == '0) && (sp_ff < RH'(FIRST_STEP_MIN))) begin
         sp_adj = RH'(FIRST_STEP_MIN);
      end
   end

   always_comb begin
      state_in    = state_ff;
      target_in   = target_ff;
      neg_in      = neg_ff;
      n_in        = n_ff;
      pdir_in     = pdir_ff;
      last_pos_in = last_pos_ff;
      steps_in    = steps_ff;
      idx_in      = idx_ff;
      ramp_in     = ramp_ff;
      peak_in     = peak_ff;
      dir_in      = dir_ff;
      active_in   = active_ff;
      sp_in       = sp_ff;
      r_status_in = r_status_ff;
      r_dir_in    = r_dir_ff;
      r_total_in  = r_total_ff;
      r_speed_in  = r_speed_ff;
      r_last_in   = r_last_ff;
      ctl.start   = 1'b0;
      ctl.op      = OP_MUL;
      opx         = '0;
      opy         = cfg.k;
      commit      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               target_in = req_if.target_position;
               state_in  = req_if.req_type ? S_STEP : S_DIFF;
            end
         end
         S_DIFF: begin
            neg_in    = diff[POS_W];
            ctl.start = 1'b1;
            ctl.op    = OP_DIV;
            opx       = XW'({mag[POS_W-1:0], {FRAC_W{1'b0}}});
            opy       = K_W'(cfg.step_dist);
            state_in  = S_NDIV;
         end
         S_NDIV: begin
            if (u_done) begin
               n_in    = nq[SW-1:0];
               pdir_in = neg_ff && !n_zero;
               if (n_bad) begin
                  r_status_in = ST_BAD_COUNT;
                  r_dir_in    = neg_ff && !n_zero;
                  r_total_in  = '0;
                  r_speed_in  = '0;
                  r_last_in   = 1'b0;
                  state_in    = S_RESP;
               end else if (cfg.k == '0) begin
                  peak_in = '0;
                  ramp_in = '0;
                  commit  = 1'b1;
               end else begin
                  ctl.start = 1'b1;
                  ctl.op    = OP_MUL;
                  opx       = XW'(nq[SW-1:0]);
                  state_in  = S_NKMUL;
               end
            end
         end
         S_NKMUL: begin
            if (u_done) begin
               ctl.start = 1'b1;
               if (XW'({cfg.v2, 17'b0}) > u_acc) begin
                  // ramp does not fit: peak from half the move
                  ctl.op   = OP_MUL;
                  opx      = XW'(n_ff >> 1);
                  state_in = S_PMUL;
               end else begin
                  peak_in  = cfg.speed_limit;
                  ctl.op   = OP_DIV;
                  opx      = XW'({cfg.v2, {FRAC_W{1'b0}}});
                  state_in = S_RDIV;
               end
            end
         end
         S_PMUL: begin
            if (u_done) begin
               ctl.start = 1'b1;
               ctl.op    = OP_SQRT;
               opx       = u_acc >> FRAC_W;
               state_in  = S_PSQRT;
            end
         end
         S_PSQRT: begin
            if (u_done) begin
               peak_in   = u_quo[MAXSPD_W-1:0];
               ctl.start = 1'b1;
               ctl.op    = OP_MUL;
               opx       = XW'(u_quo[MAXSPD_W-1:0]);
               opy       = K_W'(u_quo[MAXSPD_W-1:0]);
               state_in  = S_PPMUL;
            end
         end
         S_PPMUL: begin
            if (u_done) begin
               ctl.start = 1'b1;
               ctl.op    = OP_DIV;
               opx       = XW'({u_acc[2*MAXSPD_W-1:0], {FRAC_W{1'b0}}});
               state_in  = S_RDIV;
            end
         end
         S_RDIV: begin
            if (u_done) begin
               ramp_in = u_quo[SW-1:0];
               commit  = 1'b1;
            end
         end
         S_STEP: begin
            if (!active_ff || (idx_ff >= steps_ff)) begin
               active_in   = 1'b0;
               r_status_in = ST_NO_MOVE;
               r_dir_in    = 1'b0;
               r_total_in  = '0;
               r_speed_in  = '0;
               r_last_in   = 1'b0;
               state_in    = S_RESP;
            end else if ((idx_ff >= ramp_ff) && (idx_ff < n_mid)) begin
               sp_in    = RH'({peak_ff, 8'b0});
               state_in = S_SFIN;
            end else begin
               ctl.start = 1'b1;
               ctl.op    = OP_MUL;
               opx       = XW'(m_sel);
               state_in  = S_SMUL;
            end
         end
         S_SMUL: begin
            if (u_done) begin
               ctl.start = 1'b1;
               ctl.op    = OP_SQRT;
               opx       = u_acc;
               state_in  = S_SSQRT;
            end
         end
         S_SSQRT: begin
            if (u_done) begin
               sp_in    = u_quo[RH-1:0];
               state_in = S_SFIN;
            end
         end
         S_SFIN: begin
            r_status_in = ST_OK;
            r_dir_in    = dir_ff;
            r_total_in  = TOT_W'(steps_ff);
            r_speed_in  = (sp_adj > RH'(SPEED_SAT)) ? SPEED_SAT : sp_adj[SPEED_W-1:0];
            r_last_in   = (i_inc == {1'b0, steps_ff});
            idx_in      = i_inc[SW-1:0];
            active_in   = !(i_inc >= {1'b0, steps_ff});
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (commit) begin
         steps_in    = (state_ff == S_NDIV) ? nq[SW-1:0] : n_ff;
         idx_in      = '0;
         dir_in      = pdir_in;
         active_in   = 1'b1;
         last_pos_in = target_ff;
         r_status_in = ST_OK;
         r_dir_in    = pdir_in;
         r_total_in  = TOT_W'(steps_in);
         r_speed_in  = '0;
         r_last_in   = 1'b0;
         state_in    = S_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         last_pos_ff <= '0;
         steps_ff    <= '0;
         idx_ff      <= '0;
         ramp_ff     <= '0;
         peak_ff     <= '0;
         dir_ff      <= 1'b0;
         active_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         last_pos_ff <= last_pos_in;
         steps_ff    <= steps_in;
         idx_ff      <= idx_in;
         ramp_ff     <= ramp_in;
         peak_ff     <= peak_in;
         dir_ff      <= dir_in;
         active_ff   <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      neg_ff      <= neg_in;
      n_ff        <= n_in;
      pdir_ff     <= pdir_in;
      sp_ff       <= sp_in;
      r_status_ff <= r_status_in;
      r_dir_ff    <= r_dir_in;
      r_total_ff  <= r_total_in;
      r_speed_ff  <= r_speed_in;
      r_last_ff   <= r_last_in;
   end

   assign req_if.ready      = (state_ff == S_IDLE);
   assign rsp_if.valid      = (state_ff == S_RESP);
   assign rsp_if.status     = r_status_ff;
   assign rsp_if.direction  = r_dir_ff;
   assign rsp_if.step_count = r_total_ff;
   assign rsp_if.step_speed = r_speed_ff;
   assign rsp_if.last_step  = r_last_ff;
endmodule

// ----- hw/rtl/tmplan_checker.sv -----
module tmplan_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tmplan_pkg::STATUS_W-1:0] rsp_status,
   input logic [tmplan_pkg::TOT_W-1:0]    rsp_step_count,
   input logic [tmplan_pkg::SPEED_W-1:0]  rsp_step_speed,
   input logic                            rsp_last_step
);
   import tmplan_pkg::*;

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in flight");

   a_no_take_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result beat waits");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_speed) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   a_no_move_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NO_MOVE || rsp_status == ST_BAD_COUNT)
      |-> rsp_step_speed == '0 && !rsp_last_step && rsp_step_count == '0)
      else $error("non-ok result carries step data");
endmodule

bind trapezoidal_move_planner_top tmplan_checker u_tmplan_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_step_count (rsp_if.step_count),
   .rsp_step_speed (rsp_if.step_speed),
   .rsp_last_step  (rsp_if.last_step)
);
